@@ sv/fpa_pkg.sv @@
package fpa_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int MODE_BITS      = 4;
   localparam int QUEUE_DEPTH    = 2;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_ADD      = 4'd0,
      MODE_SUB      = 4'd1,
      MODE_MUL      = 4'd2,
      MODE_DIV      = 4'd3,
      MODE_INC      = 4'd4,
      MODE_DEC      = 4'd5,
      MODE_MIN      = 4'd6,
      MODE_MAX      = 4'd7,
      MODE_TO_INT   = 4'd8,
      MODE_FROM_INT = 4'd9
   } mode_type;

endpackage

@@ sv/fpa_if.sv @@
interface fpa_req_if #(
   parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF
);
   import fpa_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [MODE_BITS-1:0]         mode;
   logic signed [DATA_WIDTH-1:0] operand_a;
   logic signed [DATA_WIDTH-1:0] operand_b;

   modport source (output valid, mode, operand_a, operand_b, input ready);
   modport sink (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if #(
   parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] result;
   logic                         is_equal;
   logic                         is_less;
   logic                         is_greater;
   logic                         divide_by_zero;

   modport source (output valid, result, is_equal, is_less, is_greater, divide_by_zero,
                   input ready);
   modport sink (input valid, result, is_equal, is_less, is_greater, divide_by_zero,
                 output ready);
endinterface

@@ sv/fixed_point_alu_top.sv @@
// channel   direction  payload
// req_bus   in         mode, operand_a, operand_b
// rsp_bus   out        result, is_equal, is_less, is_greater, divide_by_zero
//
// one request per cycle sustained while no result is held at the output;
// the divider pipeline takes one quotient bit per stage
// a two-entry queue sits between request decode and the execution pipeline
// a held result stalls the whole pipeline; the queue still takes requests until full
// synchronous reset empties the queue and clears every stage valid
module fixed_point_alu_top #(
   parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   fpa_req_if.sink   req_bus,
   fpa_rsp_if.source rsp_bus
);
   import fpa_pkg::*;

   typedef struct packed {
      logic [MODE_BITS-1:0]  mode;
      logic [DATA_WIDTH-1:0] a;
      logic [DATA_WIDTH-1:0] b;
      logic [DATA_WIDTH-1:0] mag_a;
      logic [DATA_WIDTH-1:0] mag_b;
      logic                  neg;
      logic                  eq;
      logic                  lt;
      logic                  gt;
   } entry_type;

   logic      q_push_valid;
   logic      q_push_ready;
   entry_type q_push_data;
   logic      q_pop_valid;
   logic      q_pop_ready;
   entry_type q_pop_data;

   fpa_front #(
      .DATA_WIDTH (DATA_WIDTH),
      .entry_type (entry_type)
   ) u_front (
      .req_bus    (req_bus),
      .push_valid (q_push_valid),
      .push_data  (q_push_data),
      .push_ready (q_push_ready)
   );

   fpa_queue #(
      .entry_type (entry_type)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   fpa_back #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .entry_type (entry_type)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (q_pop_valid),
      .pop_ready (q_pop_ready),
      .pop_data  (q_pop_data),
      .rsp_bus   (rsp_bus)
   );

`ifndef SYNTHESIS
   a_request_lands: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> q_pop_valid)
      else $error("accepted request missing from queue");

   a_stall_blocks_issue: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |-> !q_pop_ready)
      else $error("pipeline issued while result held");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> q_pop_valid)
      else $error("queue refuses requests while empty");
`endif

endmodule

@@ sv/fpa_front.sv @@
module fpa_front #(
   parameter int  DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF,
   parameter type entry_type = logic
) (
   fpa_req_if.sink   req_bus,
   output logic      push_valid,
   output entry_type push_data,
   input  logic      push_ready
);
   import fpa_pkg::*;

   logic [DATA_WIDTH-1:0] a;
   logic [DATA_WIDTH-1:0] b;

   assign a = req_bus.operand_a;
   assign b = req_bus.operand_b;

   assign push_valid    = req_bus.valid;
   assign req_bus.ready = push_ready;

   always_comb begin
      push_data.mode  = req_bus.mode;
      push_data.a     = a;
      push_data.b     = b;
      // magnitudes fit unsigned even for the most negative value
      push_data.mag_a = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
      push_data.mag_b = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
      push_data.neg   = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
      push_data.eq    = (a == b);
      push_data.lt    = ($signed(a) < $signed(b));
      push_data.gt    = ($signed(a) > $signed(b));
   end

endmodule

@@ sv/fpa_queue.sv @@
module fpa_queue #(
   parameter type entry_type = logic
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_data,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_data
);
   import fpa_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/fpa_back.sv @@
module fpa_back #(
   parameter int  DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF,
   parameter int  FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF,
   parameter type entry_type = logic
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  entry_type pop_data,
   fpa_rsp_if.source rsp_bus
);
   import fpa_pkg::*;

   localparam int NUM_W  = DATA_WIDTH + FRAC_BITS;
   localparam int PROD_W = 2 * DATA_WIDTH;

   typedef struct packed {
      logic [MODE_BITS-1:0]  mode;
      logic [DATA_WIDTH-1:0] res;
      logic                  eq;
      logic                  lt;
      logic                  gt;
      logic                  neg;
      logic                  dz;
      logic [NUM_W-1:0]      num;
      logic [DATA_WIDTH-1:0] dvs;
      logic [DATA_WIDTH-1:0] rem;
      logic [DATA_WIDTH-1:0] quo;
   } pipe_type;

   logic                  adv;

   // issue stage: simple results and the multiplier
   pipe_type              iss_ff, iss_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic                  iss_valid_ff;

   // stage 0 finishes multiply, stages 1..NUM_W each take one quotient bit
   pipe_type              stg_ff [NUM_W+1];
   pipe_type              stg_in [NUM_W+1];
   logic                  stg_valid_ff [NUM_W+1];

   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] result_ff, result_in;
   logic                  eq_ff, lt_ff, gt_ff, dz_ff;

   assign adv       = !rsp_valid_ff || rsp_bus.ready;
   assign pop_ready = adv;

   always_comb begin
      iss_in      = '0;
      iss_in.mode = pop_data.mode;
      iss_in.eq   = pop_data.eq;
      iss_in.lt   = pop_data.lt;
      iss_in.gt   = pop_data.gt;
      iss_in.neg  = pop_data.neg;
      iss_in.dz   = (pop_data.mode == MODE_DIV) && (pop_data.b == '0);
      iss_in.num  = {pop_data.mag_a, {FRAC_BITS{1'b0}}};
      iss_in.dvs  = pop_data.mag_b;
      unique case (pop_data.mode)
         MODE_ADD:      iss_in.res = pop_data.a + pop_data.b;
         MODE_SUB:      iss_in.res = pop_data.a - pop_data.b;
         MODE_INC:      iss_in.res = pop_data.a + 1'b1;
         MODE_DEC:      iss_in.res = pop_data.a - 1'b1;
         MODE_MIN:      iss_in.res = pop_data.lt ? pop_data.a : pop_data.b;
         MODE_MAX:      iss_in.res = pop_data.gt ? pop_data.a : pop_data.b;
         MODE_TO_INT:   iss_in.res = DATA_WIDTH'($signed(pop_data.a) >>> FRAC_BITS);
         MODE_FROM_INT: iss_in.res = pop_data.a << FRAC_BITS;
         default:       iss_in.res = '0;
      endcase
      prod_in = PROD_W'(pop_data.mag_a) * PROD_W'(pop_data.mag_b);
   end

   always_comb begin
      logic [DATA_WIDTH-1:0] mq;
      mq        = prod_ff[FRAC_BITS +: DATA_WIDTH];
      stg_in[0] = iss_ff;
      if (iss_ff.mode == MODE_MUL) begin
         stg_in[0].res = iss_ff.neg ? (~mq + 1'b1) : mq;
      end
   end

   for (genvar k = 0; k < NUM_W; k++) begin : g_div
      always_comb begin
         logic [DATA_WIDTH-1:0] sh;
         // for a nonzero divisor the partial remainder stays below it, so its top bit is clear
         sh            = {stg_ff[k].rem[DATA_WIDTH-2:0], stg_ff[k].num[NUM_W-1]};
         stg_in[k+1]     = stg_ff[k];
         stg_in[k+1].num = stg_ff[k].num << 1;
         if (sh >= stg_ff[k].dvs) begin
            stg_in[k+1].rem = sh - stg_ff[k].dvs;
            stg_in[k+1].quo = {stg_ff[k].quo[DATA_WIDTH-2:0], 1'b1};
         end else begin
            stg_in[k+1].rem = sh;
            stg_in[k+1].quo = {stg_ff[k].quo[DATA_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      result_in = stg_ff[NUM_W].res;
      if (stg_ff[NUM_W].mode == MODE_DIV) begin
         if (stg_ff[NUM_W].dz) begin
            result_in = '0;
         end else begin
            result_in = stg_ff[NUM_W].neg ? (~stg_ff[NUM_W].quo + 1'b1) : stg_ff[NUM_W].quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i <= NUM_W; i++) begin
            stg_valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         iss_valid_ff    <= pop_valid;
         stg_valid_ff[0] <= iss_valid_ff;
         for (int i = 0; i < NUM_W; i++) begin
            stg_valid_ff[i+1] <= stg_valid_ff[i];
         end
         rsp_valid_ff <= stg_valid_ff[NUM_W];
      end
      if (adv) begin
         iss_ff  <= iss_in;
         prod_ff <= prod_in;
         for (int i = 0; i <= NUM_W; i++) begin
            stg_ff[i] <= stg_in[i];
         end
         result_ff <= result_in;
         eq_ff     <= stg_ff[NUM_W].eq;
         lt_ff     <= stg_ff[NUM_W].lt;
         gt_ff     <= stg_ff[NUM_W].gt;
         dz_ff     <= stg_ff[NUM_W].dz;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.result         = result_ff;
   assign rsp_bus.is_equal       = eq_ff;
   assign rsp_bus.is_less        = lt_ff;
   assign rsp_bus.is_greater     = gt_ff;
   assign rsp_bus.divide_by_zero = dz_ff;

endmodule
